// ===== design/aspr_pkg.sv =====
// Shared types, codes and field layout for the serial port register block.
`default_nettype none
package aspr_pkg;

  // Command codes carried in the low bits of the input tuser
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Status bit positions (bits 7:4 always read as zero)
  localparam int unsigned ST_RDRF = 0;
  localparam int unsigned ST_TDRE = 1;
  localparam int unsigned ST_DCD  = 2;
  localparam int unsigned ST_CTS  = 3;

  // Control byte fields
  localparam logic [1:0] CTL_MASTER_RESET = 2'b11;
  localparam logic [1:0] CTL_RTS_LOW_TIE  = 2'b01;
  localparam int unsigned CTL_RIE_BIT     = 7;

  // Configuration register indexes (byte address 4*i)
  localparam logic [1:0] REG_LINE_ATTACHED   = 2'd0;
  localparam logic [1:0] REG_FORCE_CARRIER   = 2'd1;
  localparam logic [1:0] REG_DTR_FOLLOWS_RTS = 2'd2;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 32;

  typedef struct packed {
    logic line_attached;
    logic force_carrier;
    logic dtr_follows_rts;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic       port_select;
    logic [7:0] write_data;
    logic       cts_line;
    logic       dcd_line;
    logic       rx_valid;
    logic [7:0] rx_char;
    logic       tx_line_done;
    logic       new_connection;
    logic       connection_lost;
  } item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [2:0] line_format;
    logic [7:0] rx_buffer;
    logic [7:0] tx_buffer;
    logic       tx_pending;
    logic       connected;
    logic       rts_deasserted;
    logic       dtr_level;
    logic       rx_irq_en;
    logic       tx_irq_en;
  } state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       rts_out;
    logic       dtr_out;
    logic       rx_enable;
    logic       rx_int_enable;
    logic       tx_int_enable;
    logic [2:0] line_format;
  } result_t;

endpackage
`default_nettype wire

// ===== design/acia_serial_port_registers.sv =====
// Top level of the serial port register block: stream channels, APB config, state.
//
// Each input beat is one bus access (read or write of the status/control or
// data port) or one service tick carrying modem levels, an offered received
// character and line events. Each input beat yields exactly one output beat
// with the read byte, any character sent to the line, and the modem and
// interrupt-enable levels after the update.
// Output: the output beat is registered and appears in the cycle after the input beat is taken.
// Throughput: one beat per cycle unless stalled; the state update and result are
// combinational flag logic, and a single output register holds the result.
// Stall: while a result waits and m_axis_tready is low, s_axis_tready drops;
// the input is taken again in the same cycle the waiting result leaves.
// Reset: status, buffers and enables clear, RTS reads deasserted, all three
// configuration bits clear, and no output beat is pending.
// Configuration: APB writes at byte addresses 0, 4, 8 (line_attached,
// force_carrier, dtr_follows_rts); write only while the block is idle.
`default_nettype none
module acia_serial_port_registers (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: write_data[7:0], cts_line[8], dcd_line[9], rx_valid[10], rx_char[18:11],
  //        tx_line_done[19], new_connection[20], connection_lost[21], zero[23:22]
  input  wire logic [aspr_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: command[1:0], port_select[2]
  input  wire logic [aspr_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: read_data[7:0], tx_valid[8], tx_char[16:9], rts_out[17], dtr_out[18],
  //        rx_enable[19], rx_int_enable[20], tx_int_enable[21], line_format[24:22],
  //        zero[31:25]
  output logic [aspr_pkg::OutDataW-1:0]      m_axis_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [aspr_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [aspr_pkg::ApbDataW-1:0] pwdata,
  output logic [aspr_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);
  import aspr_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t result_q, result_d;
  item_t   item;
  logic    out_valid_q;
  logic    in_beat;
  logic    cfg_wr;
  logic    cfg_bit;

  // Unpack the input beat
  assign item.command         = s_axis_tuser[1:0];
  assign item.port_select     = s_axis_tuser[2];
  assign item.write_data      = s_axis_tdata[7:0];
  assign item.cts_line        = s_axis_tdata[8];
  assign item.dcd_line        = s_axis_tdata[9];
  assign item.rx_valid        = s_axis_tdata[10];
  assign item.rx_char         = s_axis_tdata[18:11];
  assign item.tx_line_done    = s_axis_tdata[19];
  assign item.new_connection  = s_axis_tdata[20];
  assign item.connection_lost = s_axis_tdata[21];

  // Take a new beat whenever the output register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  aspr_update u_update (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // clear everything except RTS, which comes up deasserted
      state_q     <= '{rts_deasserted: 1'b1, default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        state_q <= state_d;
      end
      if (in_beat) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled, load with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, result_q.line_format, result_q.tx_int_enable,
                          result_q.rx_int_enable, result_q.rx_enable, result_q.dtr_out,
                          result_q.rts_out, result_q.tx_char, result_q.tx_valid,
                          result_q.read_data};

  // APB configuration: single-bit registers, word aligned
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LINE_ATTACHED:   cfg_q.line_attached   <= pwdata[0];
        REG_FORCE_CARRIER:   cfg_q.force_carrier   <= pwdata[0];
        REG_DTR_FOLLOWS_RTS: cfg_q.dtr_follows_rts <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LINE_ATTACHED:   cfg_bit = cfg_q.line_attached;
      REG_FORCE_CARRIER:   cfg_bit = cfg_q.force_carrier;
      REG_DTR_FOLLOWS_RTS: cfg_bit = cfg_q.dtr_follows_rts;
      default:             cfg_bit = 1'b0;
    endcase
  end

  assign prdata = {{(ApbDataW-1){1'b0}}, cfg_bit};

endmodule
`default_nettype wire

// ===== design/aspr_update.sv =====
// Next-state and result logic for one bus access or service tick.
`default_nettype none
module aspr_update (
  input  aspr_pkg::state_t  state_i,
  input  aspr_pkg::cfg_t    cfg_i,
  input  aspr_pkg::item_t   item_i,
  output aspr_pkg::state_t  state_o,
  output aspr_pkg::result_t result_o
);
  import aspr_pkg::*;

  state_t     nx;
  logic [7:0] rdata;
  logic       sent;
  logic [7:0] ch;

  always_comb begin
    nx    = state_i;
    rdata = 8'd0;
    sent  = 1'b0;
    ch    = 8'd0;
    unique case (item_i.command)
      CMD_READ: begin
        if (item_i.port_select) begin
          rdata             = state_i.rx_buffer;
          nx.status[ST_RDRF] = 1'b0;
        end else begin
          rdata = {4'd0, state_i.status};
        end
      end
      CMD_WRITE: begin
        if (item_i.port_select) begin
          nx.tx_buffer       = item_i.write_data;
          nx.status[ST_TDRE] = 1'b0;
          nx.tx_pending      = 1'b1;
        end else begin
          nx.line_format = item_i.write_data[4:2];
          if (item_i.write_data[1:0] == CTL_MASTER_RESET) begin
            // keep only the modem line bits
            nx.status[ST_RDRF] = 1'b0;
            nx.status[ST_TDRE] = 1'b0;
            nx.tx_pending      = 1'b0;
          end else if (cfg_i.line_attached) begin
            nx.rx_irq_en      = item_i.write_data[CTL_RIE_BIT];
            nx.tx_irq_en      = (item_i.write_data[6:5] == CTL_RTS_LOW_TIE);
            nx.rts_deasserted = item_i.write_data[6];
            if (cfg_i.dtr_follows_rts) begin
              nx.dtr_level = !item_i.write_data[6];
            end
          end
        end
      end
      CMD_TICK: begin
        if (cfg_i.line_attached) begin
          if (item_i.new_connection) begin
            nx.connected      = 1'b1;
            nx.rts_deasserted = 1'b1;
            nx.dtr_level      = 1'b0;
          end
          nx.status[ST_CTS] = !item_i.cts_line;
          nx.status[ST_DCD] = !(item_i.dcd_line || cfg_i.force_carrier);
        end
        // move a pending character onto the line unless CTS holds it off
        if (nx.tx_pending && (!cfg_i.line_attached || !nx.status[ST_CTS])) begin
          sent          = 1'b1;
          ch            = nx.tx_buffer;
          nx.tx_pending = 1'b0;
          if (cfg_i.line_attached && item_i.connection_lost) begin
            nx.connected = 1'b0;
          end
        end
        if (!nx.tx_pending && !nx.status[ST_TDRE]) begin
          if (!cfg_i.line_attached || (item_i.tx_line_done && nx.connected)) begin
            nx.status[ST_TDRE] = 1'b1;
          end
        end
        // drop characters on a full buffer or with no carrier
        if (!nx.status[ST_RDRF] && item_i.rx_valid) begin
          if (!cfg_i.line_attached || !nx.status[ST_DCD]) begin
            nx.rx_buffer       = item_i.rx_char;
            nx.status[ST_RDRF] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o                = nx;
  assign result_o.read_data     = rdata;
  assign result_o.tx_valid      = sent;
  assign result_o.tx_char       = ch;
  assign result_o.rts_out       = !nx.rts_deasserted;
  assign result_o.dtr_out       = nx.dtr_level;
  assign result_o.rx_enable     = !nx.status[ST_DCD];
  assign result_o.rx_int_enable = nx.rx_irq_en;
  assign result_o.tx_int_enable = nx.tx_irq_en;
  assign result_o.line_format   = nx.line_format;

endmodule
`default_nettype wire

// ===== verif/acia_serial_port_registers_tb.sv =====
// Self-checking testbench for the serial port register block: stream beats, APB config.
`default_nettype none
module acia_serial_port_registers_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aspr_pkg::*;

  // Command value the block must treat as a no-op
  localparam logic [1:0] CMD_NONE = 2'd3;
  // Control bit that deasserts RTS
  localparam int unsigned RTS_OFF_BIT = 6;
  // Cycles without any beat or APB access before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Length of the one long receiver hold-off, and the beat count that triggers it
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AT_BEAT = 500;
  localparam int unsigned RANDOM_PER_PHASE = 250;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  acia_serial_port_registers i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Port model: configuration and state as the block should hold them
  // ---------------------------------------------------------------------------
  cfg_t       m_cfg;
  logic [3:0] m_stat;      // RDRF, TDRE, DCD (active low), CTS (active low)
  logic [7:0] m_ctl;
  logic [7:0] m_rxbuf;
  logic [7:0] m_txbuf;
  logic       m_txpend;
  logic       m_conn;
  logic       m_rts_off;
  logic       m_dtr;
  logic       m_rie;
  logic       m_tie;

  item_t      access_q[$];   // beats waiting to be offered
  result_t    reply_q[$];    // replies owed by the block, oldest first
  item_t      cur_item;      // beat currently on the input bus
  logic       steady;        // suppress all random idling on both sides
  int         errors;
  int         beats_out;
  int         hold_left;
  logic       hold_done;
  int         quiet;

  // Apply one accepted beat to the model and return the reply it causes.
  function automatic result_t port_apply(item_t it);
    result_t    r;
    logic [7:0] w;
    r = '0;
    w = it.write_data;
    case (it.command)
      CMD_READ: begin
        if (it.port_select) begin
          r.read_data     = m_rxbuf;
          m_stat[ST_RDRF] = 1'b0;
        end else begin
          r.read_data = {4'b0000, m_stat};
        end
      end
      CMD_WRITE: begin
        if (it.port_select) begin
          m_txbuf         = w;
          m_stat[ST_TDRE] = 1'b0;
          m_txpend        = 1'b1;
        end else begin
          m_ctl = w;
          if (w[1:0] == CTL_MASTER_RESET) begin
            // Master reset: keep only the modem status bits
            m_stat[ST_RDRF] = 1'b0;
            m_stat[ST_TDRE] = 1'b0;
            m_txpend        = 1'b0;
          end else if (m_cfg.line_attached) begin
            m_rie     = w[CTL_RIE_BIT];
            m_tie     = (w[6:5] == CTL_RTS_LOW_TIE);
            m_rts_off = w[RTS_OFF_BIT];
            if (m_cfg.dtr_follows_rts) m_dtr = !m_rts_off;
          end
        end
      end
      CMD_TICK: begin
        if (m_cfg.line_attached) begin
          if (it.new_connection) begin
            m_conn    = 1'b1;
            m_rts_off = 1'b1;
            m_dtr     = 1'b0;
          end
          m_stat[ST_CTS] = !it.cts_line;
          m_stat[ST_DCD] = !(it.dcd_line || m_cfg.force_carrier);
        end
        // Send the pending character unless the partner withholds CTS
        if (m_txpend && (!m_cfg.line_attached || !m_stat[ST_CTS])) begin
          r.tx_valid = 1'b1;
          r.tx_char  = m_txbuf;
          m_txpend   = 1'b0;
          if (m_cfg.line_attached && it.connection_lost) m_conn = 1'b0;
        end
        if (!m_txpend && !m_stat[ST_TDRE] &&
            (!m_cfg.line_attached || (it.tx_line_done && m_conn)))
          m_stat[ST_TDRE] = 1'b1;
        // A full buffer or a missing carrier drops the offered character
        if (!m_stat[ST_RDRF] && it.rx_valid &&
            (!m_cfg.line_attached || !m_stat[ST_DCD])) begin
          m_rxbuf         = it.rx_char;
          m_stat[ST_RDRF] = 1'b1;
        end
      end
      default: ;
    endcase
    r.rts_out       = !m_rts_off;
    r.dtr_out       = m_dtr;
    r.rx_enable     = !m_stat[ST_DCD];
    r.rx_int_enable = m_rie;
    r.tx_int_enable = m_tie;
    r.line_format   = m_ctl[4:2];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued beats, idling about a quarter of the time
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    item_t nxt;
    logic  give;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) reply_q.push_back(port_apply(cur_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        give = (access_q.size() > 0) && (steady || $urandom_range(99) >= 25);
        if (give) begin
          nxt           = access_q.pop_front();
          cur_item     <= nxt;
          s_axis_tdata <= {2'b00, nxt.connection_lost, nxt.new_connection, nxt.tx_line_done,
                           nxt.rx_char, nxt.rx_valid, nxt.dcd_line, nxt.cts_line,
                           nxt.write_data};
          s_axis_tuser <= {nxt.port_select, nxt.command};
        end
        s_axis_tvalid <= give;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each reply beat against the oldest owed reply
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (reply_q.size() == 0) begin
          $error("reply beat 'h%0h arrived with nothing owed", m_axis_tdata);
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("read_data",     want.read_data,         m_axis_tdata[7:0]);
          check_field("tx_valid",      8'(want.tx_valid),      8'(m_axis_tdata[8]));
          check_field("tx_char",       want.tx_char,           m_axis_tdata[16:9]);
          check_field("rts_out",       8'(want.rts_out),       8'(m_axis_tdata[17]));
          check_field("dtr_out",       8'(want.dtr_out),       8'(m_axis_tdata[18]));
          check_field("rx_enable",     8'(want.rx_enable),     8'(m_axis_tdata[19]));
          check_field("rx_int_enable", 8'(want.rx_int_enable), 8'(m_axis_tdata[20]));
          check_field("tx_int_enable", 8'(want.tx_int_enable), 8'(m_axis_tdata[21]));
          check_field("line_format",   8'(want.line_format),   8'(m_axis_tdata[24:22]));
          check_field("pad",           8'h00,                  8'(m_axis_tdata[31:25]));
        end
      end
      // Hold off once for a long stretch so the block backs up onto its input
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && beats_out >= HOLD_AT_BEAT) begin
        hold_done     = 1'b1;
        hold_left     = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || $urandom_range(99) >= 25;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("acia_serial_port_registers_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t bus_rd(logic ps);
    item_t it;
    it             = '0;
    it.command     = CMD_READ;
    it.port_select = ps;
    return it;
  endfunction

  function automatic item_t bus_wr(logic ps, logic [7:0] d);
    item_t it;
    it             = '0;
    it.command     = CMD_WRITE;
    it.port_select = ps;
    it.write_data  = d;
    return it;
  endfunction

  function automatic item_t line_tick(logic cts, logic dcd, logic rxv, logic [7:0] rxc,
                                      logic done, logic newc, logic lost);
    item_t it;
    it                 = '0;
    it.command         = CMD_TICK;
    it.cts_line        = cts;
    it.dcd_line        = dcd;
    it.rx_valid        = rxv;
    it.rx_char         = rxc;
    it.tx_line_done    = done;
    it.new_connection  = newc;
    it.connection_lost = lost;
    return it;
  endfunction

  // Mostly reads, writes and ticks with plausible line levels; all fields random
  function automatic item_t random_access();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 30)      it.command = CMD_READ;
    else if (pick < 62) it.command = CMD_WRITE;
    else if (pick < 95) it.command = CMD_TICK;
    else                it.command = CMD_NONE;
    it.port_select     = 1'($urandom_range(1));
    it.write_data      = 8'($urandom_range(255));
    it.cts_line        = $urandom_range(99) < 75;
    it.dcd_line        = $urandom_range(99) < 75;
    it.rx_valid        = 1'($urandom_range(1));
    it.rx_char         = 8'($urandom_range(255));
    it.tx_line_done    = 1'($urandom_range(1));
    it.new_connection  = $urandom_range(99) < 10;
    it.connection_lost = $urandom_range(99) < 10;
    return it;
  endfunction

  // Wait until every beat is sent and answered, then let the pipe settle
  task automatic drain();
    while (access_q.size() > 0 || s_axis_tvalid || reply_q.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_LINE_ATTACHED:   m_cfg.line_attached   = v;
      REG_FORCE_CARRIER:   m_cfg.force_carrier   = v;
      REG_DTR_FOLLOWS_RTS: m_cfg.dtr_follows_rts = v;
      default: ;
    endcase
  endtask

  task automatic set_cfg(cfg_t c);
    apb_write(REG_LINE_ATTACHED,   c.line_attached);
    apb_write(REG_FORCE_CARRIER,   c.force_carrier);
    apb_write(REG_DTR_FOLLOWS_RTS, c.dtr_follows_rts);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t phase_cfg[8];
    phase_cfg = '{3'b111, 3'b000, 3'b100, 3'b110, 3'b101, 3'b010, 3'b001, 3'b011};

    // Drive every input to a known level, then hold reset
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cur_item      = '0;
    steady        = 1'b0;
    errors        = 0;
    beats_out     = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    quiet         = 0;
    m_cfg         = '0;
    m_stat        = '0;
    m_ctl         = '0;
    m_rxbuf       = '0;
    m_txbuf       = '0;
    m_txpend      = 1'b0;
    m_conn        = 1'b0;
    m_rts_off     = 1'b1;
    m_dtr         = 1'b0;
    m_rie         = 1'b0;
    m_tie         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Console port, reset configuration: buffers, full receiver, master reset
    access_q.push_back(bus_rd(1'b0));
    access_q.push_back(bus_rd(1'b1));
    access_q.push_back(bus_wr(1'b1, 8'hff));
    access_q.push_back(line_tick(1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
    access_q.push_back(line_tick(1'b0, 1'b0, 1'b1, 8'hff, 1'b0, 1'b0, 1'b0));
    access_q.push_back(bus_rd(1'b0));
    access_q.push_back(bus_rd(1'b1));
    access_q.push_back(line_tick(1'b1, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1, 1'b1));
    access_q.push_back(bus_wr(1'b0, 8'hfc));
    access_q.push_back(bus_wr(1'b1, 8'h00));
    access_q.push_back(bus_wr(1'b0, 8'h03));
    access_q.push_back(line_tick(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
    access_q.push_back('{command: CMD_NONE, write_data: 8'hff, rx_char: 8'hff, default: 1'b1});
    access_q.push_back(bus_rd(1'b1));
    drain();

    // Attached line with DTR tied to RTS: connection, RTS field, CTS, carrier
    set_cfg(3'b101);
    access_q.push_back(line_tick(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
    access_q.push_back(bus_wr(1'b0, 8'h20));
    access_q.push_back(bus_wr(1'b0, 8'hc0));
    access_q.push_back(bus_wr(1'b0, 8'h1c));
    access_q.push_back(bus_wr(1'b1, 8'h5a));
    access_q.push_back(line_tick(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
    access_q.push_back(line_tick(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1));
    access_q.push_back(line_tick(1'b1, 1'b0, 1'b1, 8'h81, 1'b0, 1'b0, 1'b0));
    access_q.push_back(bus_rd(1'b0));
    access_q.push_back(line_tick(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
    access_q.push_back(line_tick(1'b1, 1'b1, 1'b1, 8'h7e, 1'b0, 1'b0, 1'b0));
    access_q.push_back(bus_rd(1'b1));
    access_q.push_back(bus_wr(1'b0, 8'hff));
    drain();

    // Random traffic under every configuration; run one phase with no idling
    foreach (phase_cfg[p]) begin
      set_cfg(phase_cfg[p]);
      steady = (p == 3);
      repeat (RANDOM_PER_PHASE) access_q.push_back(random_access());
      drain();
    end
    steady = 1'b0;

    repeat (8) @(negedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("acia_serial_port_registers_tb: PASS");
    end else begin
      $display("acia_serial_port_registers_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== acia_serial_port_registers.f =====
design/aspr_pkg.sv
design/aspr_update.sv
design/acia_serial_port_registers.sv
verif/acia_serial_port_registers_tb.sv
